### rtl/aes_pkg.sv
// ----------------------------------------------------------------------------
// AES-128 shared definitions
// Payload types, byte tables and round functions used by the cipher cells.
// ----------------------------------------------------------------------------
package aes_pkg;

    typedef struct packed {
        logic [63:0] block_in_upper;
        logic [63:0] block_in_lower;
    } t_blk_in;

    typedef struct packed {
        logic [63:0] block_out_upper;
        logic [63:0] block_out_lower;
    } t_blk_out;

    // Byte 0 of the state sits in the most significant bits.
    typedef logic [0:15][7:0] t_state;

    // Control handed from the top level to every round cell.
    typedef struct packed {
        logic adv;
        logic dec;
        logic last;
    } t_cell_ctl;

    typedef logic [7:0] t_byte_table [256];

    typedef enum logic [1:0] {
        REG_KEY_UPPER    = 2'd0,
        REG_KEY_LOWER    = 2'd1,
        REG_DECRYPT_MODE = 2'd2
    } t_reg_idx;

    localparam int NUM_ROUNDS = 10;
    // Cycles for a new key to ripple through the key cells and their
    // InvMixColumns registers.
    localparam logic [3:0] KEY_SETTLE = 4'd12;

    localparam logic [7:0] RCON [NUM_ROUNDS] = '{
        8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1B, 8'h36
    };

    localparam t_byte_table SBOX = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    function automatic t_byte_table f_invert(input t_byte_table t);
        t_byte_table r;
        for (int i = 0; i < 256; i++) begin
            r[t[i]] = 8'(i);
        end
        return r;
    endfunction

    localparam t_byte_table INV_SBOX = f_invert(SBOX);

    function automatic logic [7:0] f_xtime(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1B : 8'h00);
    endfunction

    function automatic t_state f_sub_shift(input t_state s, input logic inv);
        t_state t;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                if (inv) begin
                    t[r + 4 * ((c + r) % 4)] = INV_SBOX[s[r + 4 * c]];
                end else begin
                    t[r + 4 * c] = SBOX[s[r + 4 * ((c + r) % 4)]];
                end
            end
        end
        return t;
    endfunction

    function automatic t_state f_mix(input t_state s, input logic inv);
        t_state t;
        logic [7:0] x1 [4];
        logic [7:0] x2 [4];
        logic [7:0] x4 [4];
        logic [7:0] x8 [4];
        logic [7:0] m2 [4];
        logic [7:0] m3 [4];
        logic [7:0] m9 [4];
        logic [7:0] mb [4];
        logic [7:0] md [4];
        logic [7:0] me [4];
        for (int c = 0; c < 4; c++) begin
            for (int k = 0; k < 4; k++) begin
                x1[k] = s[4 * c + k];
                x2[k] = f_xtime(x1[k]);
                x4[k] = f_xtime(x2[k]);
                x8[k] = f_xtime(x4[k]);
                m2[k] = x2[k];
                m3[k] = x2[k] ^ x1[k];
                m9[k] = x8[k] ^ x1[k];
                mb[k] = x8[k] ^ x2[k] ^ x1[k];
                md[k] = x8[k] ^ x4[k] ^ x1[k];
                me[k] = x8[k] ^ x4[k] ^ x2[k];
            end
            for (int r = 0; r < 4; r++) begin
                if (inv) begin
                    t[4 * c + r] = me[r] ^ mb[(r + 1) % 4] ^ md[(r + 2) % 4]
                                 ^ m9[(r + 3) % 4];
                end else begin
                    t[4 * c + r] = m2[r] ^ m3[(r + 1) % 4] ^ x1[(r + 2) % 4]
                                 ^ x1[(r + 3) % 4];
                end
            end
        end
        return t;
    endfunction

    function automatic t_state f_next_key(input t_state k, input logic [7:0] rc);
        t_state n;
        logic [7:0] t [4];
        t[0] = SBOX[k[13]] ^ rc;
        t[1] = SBOX[k[14]];
        t[2] = SBOX[k[15]];
        t[3] = SBOX[k[12]];
        for (int j = 0; j < 4; j++) begin
            n[j] = k[j] ^ t[j];
        end
        for (int i = 4; i < 16; i++) begin
            n[i] = k[i] ^ n[i - 4];
        end
        return n;
    endfunction

endpackage

### rtl/aes_key_cell.sv
// ----------------------------------------------------------------------------
// AES-128 key schedule cell
// Holds one round key, derived each cycle from its left neighbor's key.
// ----------------------------------------------------------------------------
module aes_key_cell
    import aes_pkg::*;
(
    input  logic       i_clk,
    input  t_state     i_prev_key,
    input  logic [7:0] i_rcon,
    output t_state     o_key,
    output t_state     o_imc_key
);

    t_state r_key;
    t_state r_imc;

    // The inverse-mix copy serves the equivalent inverse cipher.
    always_ff @(posedge i_clk) begin
        r_key <= f_next_key(i_prev_key, i_rcon);
        r_imc <= f_mix(r_key, 1'b1);
    end

    assign o_key     = r_key;
    assign o_imc_key = r_imc;

endmodule

### rtl/aes_round_cell.sv
// ----------------------------------------------------------------------------
// AES-128 round cell
// One cipher round, forward or inverse, with its own stage register.
// ----------------------------------------------------------------------------
module aes_round_cell
    import aes_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cell_ctl i_ctl,
    input  logic      i_vld,
    input  t_state    i_blk,
    input  t_state    i_key,
    output logic      o_vld,
    output t_state    o_blk
);

    logic   r_vld;
    t_state r_blk;
    t_state n_sub;
    t_state n_blk;

    always_comb begin
        n_sub = f_sub_shift(i_blk, i_ctl.dec);
        n_blk = (i_ctl.last ? n_sub : f_mix(n_sub, i_ctl.dec)) ^ i_key;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_ctl.adv) begin
            r_vld <= i_vld;
        end
        if (i_ctl.adv) begin
            r_blk <= n_blk;
        end
    end

    assign o_vld = r_vld;
    assign o_blk = r_blk;

endmodule

### rtl/aes128_block_cipher_top.sv
// ----------------------------------------------------------------------------
// AES-128 ECB block cipher
// Ten-round pipelined cipher with an on-the-fly key schedule chain.
// ----------------------------------------------------------------------------
// The block takes one 128-bit beat per clock while o_in_stall is low. The
// key-add stage is loaded at the edge that accepts the beat, and the ten
// round cells behind it register the block in turn; the last one drives the
// output. Every cell holds one block in flight, so a new beat can enter every
// cycle unless the input is stalled. The key schedule is a chain of ten key
// cells, each recomputing its round key from its neighbor's key in every
// cycle. After reset, and after each write of either key register, the input
// stalls while the new key ripples through the key cells and their
// InvMixColumns copies. The mode register selects encryption or decryption by
// the equivalent inverse cipher and must only be changed while no beat is in
// flight. Configuration writes are always accepted. A stall on a valid output
// beat freezes the key-add stage and the round cells.
module aes128_block_cipher_top
    import aes_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_blk_in     i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_blk_out    o_out_data,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data
);

    logic [63:0] r_key_hi;
    logic [63:0] r_key_lo;
    logic        r_dec;
    logic [3:0]  r_busy;
    logic        r_v0;
    t_state      r_d0;

    logic      adv;
    logic      busy;
    logic      key_wr;
    t_cell_ctl ctl [1:NUM_ROUNDS];

    t_state rk  [NUM_ROUNDS + 1];
    t_state imc [1:NUM_ROUNDS];
    t_state cell_key [1:NUM_ROUNDS];
    logic   cv  [NUM_ROUNDS + 1];
    t_state cd  [NUM_ROUNDS + 1];

    assign o_cfg_ready = 1'b1;
    assign key_wr = i_cfg_valid
                  && (i_cfg_index == REG_KEY_UPPER || i_cfg_index == REG_KEY_LOWER);
    assign busy = (r_busy != 4'd0);

    // The whole row moves unless a finished block is held at the output.
    assign adv        = !(o_out_valid && i_out_stall);
    assign o_in_stall = !adv || busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_hi <= '0;
            r_key_lo <= '0;
            r_dec    <= 1'b0;
            r_busy   <= KEY_SETTLE;
            r_v0     <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    REG_KEY_UPPER:    r_key_hi <= i_cfg_data;
                    REG_KEY_LOWER:    r_key_lo <= i_cfg_data;
                    REG_DECRYPT_MODE: r_dec    <= i_cfg_data[0];
                    default:          ;
                endcase
            end
            if (key_wr) begin
                r_busy <= KEY_SETTLE;
            end else if (busy) begin
                r_busy <= r_busy - 4'd1;
            end
            if (adv) begin
                r_v0 <= i_in_valid && !busy;
            end
        end
        if (adv) begin
            r_d0 <= t_state'(i_in_data) ^ (r_dec ? rk[NUM_ROUNDS] : rk[0]);
        end
    end

    assign rk[0]  = t_state'({r_key_hi, r_key_lo});
    assign cv[0]  = r_v0;
    assign cd[0]  = r_d0;

    genvar g;
    generate
        for (g = 1; g <= NUM_ROUNDS; g++) begin : g_cell
            aes_key_cell u_key (
                .i_clk      (i_clk),
                .i_prev_key (rk[g - 1]),
                .i_rcon     (RCON[g - 1]),
                .o_key      (rk[g]),
                .o_imc_key  (imc[g])
            );

            // Decryption walks the schedule backwards through the mixed keys.
            if (g == NUM_ROUNDS) begin : g_last
                assign cell_key[g] = r_dec ? rk[0] : rk[g];
            end else begin : g_mid
                assign cell_key[g] = r_dec ? imc[NUM_ROUNDS - g] : rk[g];
            end

            assign ctl[g] = '{adv: adv, dec: r_dec, last: (g == NUM_ROUNDS)};

            aes_round_cell u_round (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctl   (ctl[g]),
                .i_vld   (cv[g - 1]),
                .i_blk   (cd[g - 1]),
                .i_key   (cell_key[g]),
                .o_vld   (cv[g]),
                .o_blk   (cd[g])
            );
        end
    endgenerate

    assign o_out_valid = cv[NUM_ROUNDS];
    assign o_out_data  = t_blk_out'(cd[NUM_ROUNDS]);

`ifndef NO_ASSERTIONS
    a_key_write_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        key_wr |=> o_in_stall)
        else $error("input not stalled after a key write");

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> r_v0)
        else $error("accepted beat did not enter the first stage");

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> o_in_stall)
        else $error("input accepted while the key schedule settles");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_data)))
        else $error("stalled output beat changed");
`endif

endmodule

### tb/sv/tb_aes128_block_cipher_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// AES-128 ECB cipher testbench
// Drives blocks through the cipher under random valid and stall gaps, checks
// every result against a behavioral AES-128 model kept in the testbench, and
// walks through several keys and both modes, with the key written while idle.
// ----------------------------------------------------------------------------
module tb_aes128_block_cipher_top;
    import aes_pkg::*;

    typedef logic [0:15][7:0] t_bytes;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    t_blk_in     i_in_data = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    t_blk_out    o_out_data;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = '0;
    logic [63:0] i_cfg_data = '0;

    aes128_block_cipher_top dut (.*);

    always #10 i_clk = ~i_clk;

    // Model state: the configured key and mode, and the expanded schedule.
    logic [63:0] key_hi, key_lo;
    logic        mode_dec;
    t_bytes      enc_keys [11];
    t_bytes      dec_keys [11];
    logic [7:0]  fwd_box [256];
    logic [7:0]  inv_box [256];

    t_blk_out    expected_blocks [$];
    int          mismatches = 0;
    int          idle_cycles = 0;
    bit          hold_output = 1'b0;
    bit          random_stalls = 1'b1;
    bit          gaps_on = 1'b1;

    localparam int LATENCY = 16;
    localparam int WATCHDOG_LIMIT = 20000;

    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] r;
        logic [7:0] x;
        r = '0;
        x = a;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) r ^= x;
            x = {x[6:0], 1'b0} ^ (x[7] ? 8'h1B : 8'h00);
        end
        return r;
    endfunction

    function automatic t_bytes sub_shift(input t_bytes s, input logic inv);
        t_bytes t;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                if (inv) t[r + 4 * ((c + r) % 4)] = inv_box[s[r + 4 * c]];
                else t[r + 4 * c] = fwd_box[s[r + 4 * ((c + r) % 4)]];
            end
        end
        return t;
    endfunction

    function automatic t_bytes mix_columns(input t_bytes s, input logic inv);
        t_bytes t;
        logic [7:0] m [4];
        logic [7:0] v;
        if (inv) begin
            m = '{8'd14, 8'd11, 8'd13, 8'd9};
        end else begin
            m = '{8'd2, 8'd3, 8'd1, 8'd1};
        end
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                v = '0;
                for (int k = 0; k < 4; k++) v ^= gf_mul(s[4 * c + k], m[(k - r + 4) % 4]);
                t[4 * c + r] = v;
            end
        end
        return t;
    endfunction

    // Rebuilds the eleven round keys, plus the InvMixColumns copies used on
    // the decrypt path of the equivalent inverse cipher.
    function automatic void expand_key();
        logic [7:0] w [176];
        logic [7:0] t [4];
        logic [7:0] tmp;
        logic [7:0] rc;
        t_bytes     k;
        k = {key_hi, key_lo};
        rc = 8'h01;
        for (int i = 0; i < 16; i++) w[i] = k[i];
        for (int i = 4; i < 44; i++) begin
            for (int j = 0; j < 4; j++) t[j] = w[4 * (i - 1) + j];
            if (i % 4 == 0) begin
                tmp = t[0];
                t[0] = fwd_box[t[1]] ^ rc;
                t[1] = fwd_box[t[2]];
                t[2] = fwd_box[t[3]];
                t[3] = fwd_box[tmp];
                rc = gf_mul(rc, 8'h02);
            end
            for (int j = 0; j < 4; j++) w[4 * i + j] = w[4 * (i - 4) + j] ^ t[j];
        end
        for (int r = 0; r < 11; r++) begin
            for (int i = 0; i < 16; i++) k[i] = w[16 * r + i];
            enc_keys[r] = k;
            dec_keys[r] = (r == 0 || r == 10) ? k : mix_columns(k, 1'b1);
        end
    endfunction

    function automatic t_blk_out cipher_block(input t_blk_in b);
        t_bytes s;
        s = {b.block_in_upper, b.block_in_lower};
        if (mode_dec) begin
            s ^= dec_keys[10];
            for (int r = 9; r >= 1; r--) begin
                s = mix_columns(sub_shift(s, 1'b1), 1'b1) ^ dec_keys[r];
            end
            s = sub_shift(s, 1'b1) ^ dec_keys[0];
        end else begin
            s ^= enc_keys[0];
            for (int r = 1; r < 10; r++) begin
                s = mix_columns(sub_shift(s, 1'b0), 1'b0) ^ enc_keys[r];
            end
            s = sub_shift(s, 1'b0) ^ enc_keys[10];
        end
        return {s[0:7], s[8:15]};
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %h expected %h", what, got, want);
        mismatches++;
    endtask

    // Output side: stall pattern and result checker.
    initial begin : out_stall_gen
        int gap;
        forever begin
            gap = (random_stalls && !hold_output) ? $urandom_range(0, 19) : 0;
            if (gap > 0 && $urandom_range(0, 3) == 0) gap = 0;
            repeat (gap) begin
                @(posedge i_clk);
                i_out_stall <= 1'b1;
            end
            @(posedge i_clk);
            i_out_stall <= hold_output;
            while (hold_output || !(o_out_valid && !i_out_stall)) begin
                @(posedge i_clk);
                i_out_stall <= hold_output;
            end
        end
    end

    always @(posedge i_clk) begin
        t_blk_out want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_blocks.size() == 0) begin
                report_mismatch("unexpected beat", o_out_data.block_out_upper, 64'h0);
            end else begin
                want = expected_blocks.pop_front();
                if (o_out_data.block_out_upper !== want.block_out_upper)
                    report_mismatch("upper", o_out_data.block_out_upper,
                                    want.block_out_upper);
                if (o_out_data.block_out_lower !== want.block_out_lower)
                    report_mismatch("lower", o_out_data.block_out_lower,
                                    want.block_out_lower);
            end
        end
    end

    // The watchdog counts cycles with no handshake while the output is not held.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || (i_cfg_valid && o_cfg_ready) || hold_output)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // Sends one block, after a random gap, and records its expected result.
    // Valid stays high after the accepting edge so that a block sent with no
    // gap follows back to back; idle_input drops it.
    task automatic send_block(input logic [63:0] hi, input logic [63:0] lo);
        int gap;
        gap = gaps_on ? $urandom_range(0, 19) : 0;
        if (gap > 0 && $urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= '{block_in_upper: hi, block_in_lower: lo};
        do @(posedge i_clk); while (o_in_stall);
        expected_blocks.push_back(cipher_block('{block_in_upper: hi, block_in_lower: lo}));
    endtask

    task automatic idle_input();
        i_in_valid <= 1'b0;
    endtask

    task automatic drain();
        idle_input();
        while (expected_blocks.size() != 0) @(posedge i_clk);
        repeat (LATENCY) @(posedge i_clk);
    endtask

    // Register writes happen only after the pipeline has drained.
    task automatic write_reg(input t_reg_idx idx, input logic [63:0] value);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            REG_KEY_UPPER: begin
                key_hi = value;
                expand_key();
            end
            REG_KEY_LOWER: begin
                key_lo = value;
                expand_key();
            end
            REG_DECRYPT_MODE: mode_dec = value[0];
            default: ;
        endcase
    endtask

    task automatic send_random(input int count);
        repeat (count) send_block({$urandom, $urandom}, {$urandom, $urandom});
    endtask

    // Known FIPS-197 vector plus extremes, both modes, under the reset key too.
    task automatic test_directed();
        send_block('0, '0);
        send_block('1, '1);
        send_block(64'h8000_0000_0000_0000, 64'h1);
        write_reg(REG_KEY_UPPER, 64'h0001_0203_0405_0607);
        write_reg(REG_KEY_LOWER, 64'h0809_0a0b_0c0d_0e0f);
        send_block(64'h0011_2233_4455_6677, 64'h8899_aabb_ccdd_eeff);
        send_block('0, '1);
        write_reg(REG_DECRYPT_MODE, 64'h1);
        send_block(64'h69c4_e0d8_6a7b_0430, 64'hd8cd_b780_70b4_c55a);
        send_block('1, '0);
        // Only bit 0 of the mode value counts.
        write_reg(REG_DECRYPT_MODE, 64'hFFFF_FFFF_FFFF_FFFE);
        send_block(64'h0011_2233_4455_6677, 64'h8899_aabb_ccdd_eeff);
        write_reg(REG_KEY_UPPER, '1);
        write_reg(REG_KEY_LOWER, '1);
        send_block('0, '0);
        send_block('1, '1);
        write_reg(REG_DECRYPT_MODE, 64'h1);
        send_block('0, '0);
        send_block('1, '1);
        // The unused register index is ignored.
        write_reg(t_reg_idx'(2'd3), '1);
        send_block(64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa);
    endtask

    // Random blocks over several random keys in both modes.
    task automatic test_random_keys();
        for (int phase = 0; phase < 10; phase++) begin
            write_reg(REG_KEY_UPPER, {$urandom, $urandom});
            if ($urandom_range(0, 1)) write_reg(REG_KEY_LOWER, {$urandom, $urandom});
            write_reg(REG_DECRYPT_MODE, 64'($urandom_range(0, 1)));
            send_random(100);
        end
    endtask

    // The receiver holds off while blocks keep arriving, so the pipeline fills
    // and stalls its input; then the sender waits for every result and sends more.
    task automatic test_backpressure();
        int hold;
        hold = 400;
        hold_output = 1'b1;
        fork
            begin
                repeat (hold) @(posedge i_clk);
                hold_output = 1'b0;
            end
            send_random(40);
        join
        idle_input();
        while (expected_blocks.size() != 0) @(posedge i_clk);
        send_random(20);
    endtask

    // Full rate on both sides.
    task automatic test_line_rate();
        gaps_on = 1'b0;
        random_stalls = 1'b0;
        send_random(150);
        gaps_on = 1'b1;
        random_stalls = 1'b1;
    endtask

    initial begin : main
        int waited;
        for (int i = 0; i < 256; i++) begin
            fwd_box[i] = SBOX[i];
            inv_box[SBOX[i]] = 8'(i);
        end
        key_hi = '0;
        key_lo = '0;
        mode_dec = 1'b0;
        expand_key();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_random_keys();
        test_backpressure();
        test_line_rate();
        idle_input();
        waited = 0;
        while (expected_blocks.size() != 0 && waited < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (LATENCY) @(posedge i_clk);
        if (mismatches == 0 && expected_blocks.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
